// ----- hdl/amfm_tpc_pkg.sv -----
// amfm_tpc_pkg: shared types and constants for the am/fm tuner preset controller
// holds command, status and register index codes plus reset values
// no dependencies
package amfm_tpc_pkg;

    // field widths
    localparam int STATION_W  = 11;
    localparam int STEP_W     = 8;
    localparam int LEVEL_W    = 7;
    localparam int VOLREQ_W   = 11;
    localparam int BUTTON_W   = 4;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // default preset bank depth
    localparam int PRESET_COUNT_DEF = 5;

    // reset values of the configuration registers
    localparam logic [STATION_W-1:0] AM_MIN_RST       = 11'd530;
    localparam logic [STATION_W-1:0] AM_MAX_RST       = 11'd1700;
    localparam logic [STATION_W-1:0] FM_MIN_RST       = 11'd879;
    localparam logic [STATION_W-1:0] FM_MAX_RST       = 11'd1079;
    localparam logic [STEP_W-1:0]    AM_STEP_RST      = 8'd10;
    localparam logic [STEP_W-1:0]    FM_STEP_RST      = 8'd2;
    localparam logic [LEVEL_W-1:0]   VOLUME_LIMIT_RST = 7'd100;

    // command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_POWER  = 3'd0,
        MODE_VOLUME = 3'd1,
        MODE_BAND   = 3'd2,
        MODE_STORE  = 3'd3,
        MODE_RECALL = 3'd4,
        MODE_SCAN_UP = 3'd5,
        MODE_SCAN_DN = 3'd6,
        MODE_TUNE   = 3'd7
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_VOL_ZERO  = 3'd1,
        ST_VOL_CAP   = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AM_MIN       = 3'd0,
        REG_AM_MAX       = 3'd1,
        REG_FM_MIN       = 3'd2,
        REG_FM_MAX       = 3'd3,
        REG_AM_STEP      = 3'd4,
        REG_FM_STEP      = 3'd5,
        REG_VOLUME_LIMIT = 3'd6
    } cfg_reg_t;

    // one result item
    typedef struct packed {
        logic                 power_on;
        logic                 band_is_fm;
        logic [STATION_W-1:0] station;
        logic [LEVEL_W-1:0]   volume_level;
        logic [STATION_W-1:0] band_last_station;
        status_t              status;
    } result_t;

endpackage

// ----- hdl/am_fm_tuner_preset_controller.sv -----
// am_fm_tuner_preset_controller: radio tuner command processor with per-band presets
// each result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one request per cycle while the skid entry is empty; the result register plus one skid entry
// let one more request in while the output is stalled
// reset (aresetn, synchronous, active low): power off, AM band, station 530,
// volume 0, no last stations, presets at band minimum, registers at defaults
// depends on amfm_tpc_pkg
module am_fm_tuner_preset_controller
    import amfm_tpc_pkg::*;
#(
    parameter int PRESET_COUNT = PRESET_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // command channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic signed [VOLREQ_W-1:0] s_volume_request,
    input  logic [BUTTON_W-1:0]   s_button_index,
    input  logic [STATION_W-1:0]  s_station_request,

    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_power_on,
    output logic                  m_band_is_fm,
    output logic [STATION_W-1:0]  m_station,
    output logic [LEVEL_W-1:0]    m_volume_level,
    output logic [STATION_W-1:0]  m_band_last_station,
    output logic [STATUS_W-1:0]   m_status
);

    localparam int PIDX_W = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;
    localparam int BTN_CMP_W = BUTTON_W + 1;

    // configuration registers
    logic [STATION_W-1:0] am_min_reg, am_max_reg, fm_min_reg, fm_max_reg;
    logic [STEP_W-1:0]    am_step_reg, fm_step_reg;
    logic [LEVEL_W-1:0]   volume_limit_reg;

    // tuner state
    logic                 powered_reg, powered_next;
    logic                 band_fm_reg, band_fm_next;
    logic [STATION_W-1:0] tuned_reg, tuned_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [LEVEL_W-1:0]   saved_level_reg, saved_level_next;
    logic [STATION_W-1:0] last_am_reg, last_am_next;
    logic [STATION_W-1:0] last_fm_reg, last_fm_next;
    logic [STATION_W-1:0] presets_am_reg [PRESET_COUNT];
    logic [STATION_W-1:0] presets_fm_reg [PRESET_COUNT];

    // output register and skid entry
    result_t out_reg, skid_reg, result_next;
    logic    m_valid_reg, skid_valid_reg;

    logic    s_accept, out_free;
    logic    btn_ok, store_en;
    logic [PIDX_W-1:0]    btn_idx;
    logic [STATION_W-1:0] lo, hi, preset_rd, last_cur, scan_val, new_last;
    logic [STEP_W-1:0]    stp;
    logic [STATION_W:0]   up_sum, lo_plus;
    logic                 set_last;
    status_t              status_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            am_min_reg       <= AM_MIN_RST;
            am_max_reg       <= AM_MAX_RST;
            fm_min_reg       <= FM_MIN_RST;
            fm_max_reg       <= FM_MAX_RST;
            am_step_reg      <= AM_STEP_RST;
            fm_step_reg      <= FM_STEP_RST;
            volume_limit_reg <= VOLUME_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AM_MIN:       am_min_reg       <= cfg_data;
                REG_AM_MAX:       am_max_reg       <= cfg_data;
                REG_FM_MIN:       fm_min_reg       <= cfg_data;
                REG_FM_MAX:       fm_max_reg       <= cfg_data;
                REG_AM_STEP:      am_step_reg      <= cfg_data[STEP_W-1:0];
                REG_FM_STEP:      fm_step_reg      <= cfg_data[STEP_W-1:0];
                REG_VOLUME_LIMIT: volume_limit_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // current band limits and preset lookup
    assign lo       = band_fm_reg ? fm_min_reg  : am_min_reg;
    assign hi       = band_fm_reg ? fm_max_reg  : am_max_reg;
    assign stp      = band_fm_reg ? fm_step_reg : am_step_reg;
    assign btn_ok   = {1'b0, s_button_index} < BTN_CMP_W'(PRESET_COUNT);
    assign btn_idx  = PIDX_W'(s_button_index);
    assign preset_rd = band_fm_reg ? presets_fm_reg[btn_idx] : presets_am_reg[btn_idx];
    assign up_sum   = {1'b0, tuned_reg} + (STATION_W+1)'(stp);
    assign lo_plus  = {1'b0, lo} + (STATION_W+1)'(stp);

    // command decode and next state
    always_comb begin
        powered_next     = powered_reg;
        band_fm_next     = band_fm_reg;
        tuned_next       = tuned_reg;
        level_next       = level_reg;
        saved_level_next = saved_level_reg;
        status_next      = ST_OK;
        store_en         = 1'b0;
        set_last         = 1'b0;
        new_last         = tuned_reg;
        scan_val         = tuned_reg;

        unique case (mode_t'(s_mode))
            MODE_POWER: begin
                if (powered_reg) begin
                    saved_level_next = level_reg;
                    level_next       = '0;
                    powered_next     = 1'b0;
                end else begin
                    level_next   = saved_level_reg;
                    powered_next = 1'b1;
                end
            end
            MODE_VOLUME: begin
                if (!powered_reg || s_volume_request[VOLREQ_W-1]) begin
                    level_next  = '0;
                    status_next = ST_VOL_ZERO;
                end else if (s_volume_request[VOLREQ_W-2:0] >
                             (VOLREQ_W-1)'(volume_limit_reg)) begin
                    level_next  = volume_limit_reg;
                    status_next = ST_VOL_CAP;
                end else begin
                    level_next = s_volume_request[LEVEL_W-1:0];
                end
            end
            MODE_BAND: begin
                band_fm_next = !band_fm_reg;
                if (!band_fm_reg) begin
                    tuned_next = (last_fm_reg == '0) ? fm_min_reg : last_fm_reg;
                end else begin
                    tuned_next = (last_am_reg == '0) ? am_min_reg : last_am_reg;
                end
            end
            MODE_STORE: begin
                if (!btn_ok) begin
                    status_next = ST_BAD_INDEX;
                end else begin
                    store_en = 1'b1;
                end
            end
            MODE_RECALL: begin
                if (!btn_ok) begin
                    status_next = ST_BAD_INDEX;
                end else begin
                    tuned_next = preset_rd;
                    set_last   = 1'b1;
                    new_last   = preset_rd;
                end
            end
            MODE_SCAN_UP: begin
                if (tuned_reg >= hi) begin
                    scan_val = lo;
                end else if (up_sum > {1'b0, hi}) begin
                    scan_val = hi;
                end else begin
                    scan_val = up_sum[STATION_W-1:0];
                end
                tuned_next = scan_val;
                set_last   = 1'b1;
                new_last   = scan_val;
            end
            MODE_SCAN_DN: begin
                if (tuned_reg <= lo) begin
                    scan_val = hi;
                end else if ({1'b0, tuned_reg} < lo_plus) begin
                    scan_val = lo;
                end else begin
                    scan_val = tuned_reg - STATION_W'(stp);
                end
                tuned_next = scan_val;
                set_last   = 1'b1;
                new_last   = scan_val;
            end
            MODE_TUNE: begin
                if (s_station_request >= lo && s_station_request <= hi) begin
                    tuned_next = s_station_request;
                    set_last   = 1'b1;
                    new_last   = s_station_request;
                end else begin
                    status_next = ST_RANGE;
                end
            end
            default: ;
        endcase

        // last station of the band in use
        last_am_next = last_am_reg;
        last_fm_next = last_fm_reg;
        if (set_last) begin
            if (band_fm_reg) begin
                last_fm_next = new_last;
            end else begin
                last_am_next = new_last;
            end
        end

        last_cur = band_fm_next ? last_fm_next : last_am_next;

        result_next.power_on          = powered_next;
        result_next.band_is_fm        = band_fm_next;
        result_next.station           = tuned_next;
        result_next.volume_level      = level_next;
        result_next.band_last_station = last_cur;
        result_next.status            = status_next;
    end

    // tuner state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            powered_reg     <= 1'b0;
            band_fm_reg     <= 1'b0;
            tuned_reg       <= AM_MIN_RST;
            level_reg       <= '0;
            saved_level_reg <= '0;
            last_am_reg     <= '0;
            last_fm_reg     <= '0;
        end else if (s_accept) begin
            powered_reg     <= powered_next;
            band_fm_reg     <= band_fm_next;
            tuned_reg       <= tuned_next;
            level_reg       <= level_next;
            saved_level_reg <= saved_level_next;
            last_am_reg     <= last_am_next;
            last_fm_reg     <= last_fm_next;
        end
    end

    // preset banks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PRESET_COUNT; i++) begin
                presets_am_reg[i] <= AM_MIN_RST;
                presets_fm_reg[i] <= FM_MIN_RST;
            end
        end else if (s_accept && store_en) begin
            if (band_fm_reg) begin
                presets_fm_reg[btn_idx] <= tuned_reg;
            end else begin
                presets_am_reg[btn_idx] <= tuned_reg;
            end
        end
    end

    // result register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= result_next;
            end
        end else if (s_accept) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_power_on          = out_reg.power_on;
    assign m_band_is_fm        = out_reg.band_is_fm;
    assign m_station           = out_reg.station;
    assign m_volume_level      = out_reg.volume_level;
    assign m_band_last_station = out_reg.band_last_station;
    assign m_status            = out_reg.status;

endmodule
